>>> rtl/hmsct_pkg.sv
// Shared types and constants of the H:M:S countdown timer.
// No dependencies; every other file of the block imports this package.
package hmsct_pkg;

  // Operating modes, also the code on the mode output.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;
  localparam logic [1:0] MODE_FINISH = 2'd3;

  // Command codes of an input word.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Panel key codes.
  localparam logic [1:0] PANEL_NONE  = 2'd0;
  localparam logic [1:0] PANEL_START = 2'd1;
  localparam logic [1:0] PANEL_NEXT  = 2'd2;
  localparam logic [1:0] PANEL_INC   = 2'd3;

  // Remote key codes.
  localparam logic [2:0] REMOTE_NONE   = 3'd0;
  localparam logic [2:0] REMOTE_PLAY   = 3'd1;
  localparam logic [2:0] REMOTE_CANCEL = 3'd2;
  localparam logic [2:0] REMOTE_NEXT   = 3'd3;
  localparam logic [2:0] REMOTE_PREV   = 3'd4;
  localparam logic [2:0] REMOTE_PLUS   = 3'd5;
  localparam logic [2:0] REMOTE_MINUS  = 3'd6;

  // Field selection codes.
  localparam logic [1:0] FIELD_HOURS   = 2'd0;
  localparam logic [1:0] FIELD_MINUTES = 2'd1;
  localparam logic [1:0] FIELD_SECONDS = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TICKS_PER_SECOND  = 2'd0;
  localparam logic [1:0] REG_BLINK_TICKS       = 2'd1;
  localparam logic [1:0] REG_BEEP_TOGGLE_TICKS = 2'd2;
  localparam logic [1:0] REG_BEEP_DURATION     = 2'd3;

  // Register reset values.
  localparam logic [5:0] TPS_RESET      = 6'd20;
  localparam logic [3:0] BLINK_RESET    = 4'd5;
  localparam logic [3:0] BEEP_TOG_RESET = 4'd4;
  localparam logic [7:0] BEEP_DUR_RESET = 8'd200;

  // Field limits.
  localparam logic [4:0] HOUR_TOP = 5'd23;
  localparam logic [5:0] MS_TOP   = 6'd59;

  // Current configuration as seen by the core.
  typedef struct packed {
    logic [5:0] ticks_per_second;
    logic [3:0] blink_ticks;
    logic [3:0] beep_toggle_ticks;
    logic [7:0] beep_duration;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] mode;
    logic [1:0] selected_field;
    logic       counting;
    logic       blink;
    logic [1:0] blank_field;
    logic       beeper;
  } res_t;

endpackage

>>> rtl/hmsct_cfg_regs.sv
// Configuration register file of the countdown timer.
// Depends on hmsct_pkg for register indexes, reset values and cfg_t.
module hmsct_cfg_regs
  import hmsct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Register writes, truncated to the width of each register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second  <= TPS_RESET;
      cfg_q.blink_ticks       <= BLINK_RESET;
      cfg_q.beep_toggle_ticks <= BEEP_TOG_RESET;
      cfg_q.beep_duration     <= BEEP_DUR_RESET;
    end else if (wr_en) begin
      case (cfg_index_i)
        REG_TICKS_PER_SECOND:  cfg_q.ticks_per_second  <= cfg_data_i[5:0];
        REG_BLINK_TICKS:       cfg_q.blink_ticks       <= cfg_data_i[3:0];
        REG_BEEP_TOGGLE_TICKS: cfg_q.beep_toggle_ticks <= cfg_data_i[3:0];
        REG_BEEP_DURATION:     cfg_q.beep_duration     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/hmsct_core.sv
// Timer state and its update for one tick or key poll.
// Depends on hmsct_pkg for mode and key codes, cfg_t and res_t.
module hmsct_core
  import hmsct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       cmd_i,
  input  logic [1:0] panel_i,
  input  logic [2:0] remote_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  // Increment with wrap to zero above the top value.
  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] top);
    wrap_up = (v >= top) ? 6'd0 : v + 6'd1;
  endfunction

  // Decrement with wrap to the top value from zero or out of range.
  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] top);
    wrap_down = (v == 6'd0 || v > top) ? top : v - 6'd1;
  endfunction

  logic [4:0] hour_q, hour_d;
  logic [5:0] min_q, min_d;
  logic [5:0] sec_q, sec_d;
  logic [1:0] mode_q, mode_d;
  logic [1:0] field_q, field_d;
  logic       run_q, run_d;
  logic       blink_q, blink_d;
  logic       armed_q, armed_d;
  logic [7:0] left_q, left_d;
  logic       level_q, level_d;
  logic [5:0] sdiv_q, sdiv_d;
  logic [3:0] bdiv_q, bdiv_d;
  logic [3:0] pdiv_q, pdiv_d;

  logic [5:0] sdiv_inc;
  logic [3:0] bdiv_inc, pdiv_inc;
  logic       sec_fire, blk_fire, bep_fire;
  logic       start, cancel, up, down, run_tog;
  logic [1:0] field_a;
  logic [5:0] hour_w, adj_v, adj_top, adj_u, adj_r;
  logic       zero_now, zero_set;

  // Tick dividers: count up, return to zero and fire at the limit.
  always_comb begin
    sdiv_inc = sdiv_q + 6'd1;
    bdiv_inc = bdiv_q + 4'd1;
    pdiv_inc = pdiv_q + 4'd1;
    sec_fire = (sdiv_inc >= cfg_i.ticks_per_second) || (sdiv_inc == 6'd0);
    blk_fire = (bdiv_inc >= cfg_i.blink_ticks) || (bdiv_inc == 4'd0);
    bep_fire = (pdiv_inc >= cfg_i.beep_toggle_ticks) || (pdiv_inc == 4'd0);
  end

  // Key decoding shared by all modes.
  assign start  = (panel_i == PANEL_START) || (remote_i == REMOTE_PLAY);
  assign cancel = (panel_i == PANEL_INC) || (remote_i == REMOTE_CANCEL);
  assign up     = (panel_i == PANEL_INC) || (remote_i == REMOTE_PLUS);
  assign down   = (remote_i == REMOTE_MINUS);

  // Field selection after next and previous keys.
  always_comb begin
    field_a = field_q;
    if (panel_i == PANEL_NEXT || remote_i == REMOTE_NEXT) begin
      field_a = (field_a >= FIELD_SECONDS) ? FIELD_HOURS : field_a + 2'd1;
    end
    if (remote_i == REMOTE_PREV) begin
      field_a = (field_a == FIELD_HOURS || field_a > FIELD_SECONDS) ?
                FIELD_SECONDS : field_a - 2'd1;
    end
  end

  // Adjust the selected field: increment first, then decrement.
  always_comb begin
    hour_w = {1'b0, hour_q};
    case (field_a)
      FIELD_HOURS: begin
        adj_v   = hour_w;
        adj_top = {1'b0, HOUR_TOP};
      end
      FIELD_MINUTES: begin
        adj_v   = min_q;
        adj_top = MS_TOP;
      end
      default: begin
        adj_v   = sec_q;
        adj_top = MS_TOP;
      end
    endcase
    adj_u = up ? wrap_up(adj_v, adj_top) : adj_v;
    adj_r = down ? wrap_down(adj_u, adj_top) : adj_u;
  end

  assign zero_now = (hour_q == 5'd0) && (min_q == 6'd0) && (sec_q == 6'd0);
  assign run_tog  = run_q ^ start;

  // Next state for one word.
  always_comb begin
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    mode_d  = mode_q;
    field_d = field_q;
    run_d   = run_q;
    blink_d = blink_q;
    armed_d = armed_q;
    left_d  = left_q;
    level_d = level_q;
    sdiv_d  = sdiv_q;
    bdiv_d  = bdiv_q;
    pdiv_d  = pdiv_q;
    zero_set = 1'b0;
    if (cmd_i == CMD_TICK) begin
      sdiv_d = sec_fire ? 6'd0 : sdiv_inc;
      bdiv_d = blk_fire ? 4'd0 : bdiv_inc;
      pdiv_d = bep_fire ? 4'd0 : pdiv_inc;
      if (blk_fire) begin
        blink_d = ~blink_q;
      end
      // Countdown with borrow; nothing moves at zero.
      if (run_q && sec_fire) begin
        if (sec_q != 6'd0) begin
          sec_d = sec_q - 6'd1;
        end else if (min_q != 6'd0) begin
          min_d = min_q - 6'd1;
          sec_d = MS_TOP;
        end else if (hour_q != 5'd0) begin
          hour_d = hour_q - 5'd1;
          min_d  = MS_TOP;
          sec_d  = MS_TOP;
        end
      end
      if (armed_q && left_q != 8'd0) begin
        left_d = left_q - 8'd1;
        if (bep_fire) begin
          level_d = ~level_q;
        end
      end
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          hour_d = 5'd0;
          min_d  = 6'd0;
          sec_d  = 6'd0;
          if (start) begin
            mode_d = MODE_SET;
          end
        end
        MODE_SET: begin
          field_d = field_a;
          case (field_a)
            FIELD_HOURS:   hour_d = adj_r[4:0];
            FIELD_MINUTES: min_d  = adj_r;
            default:       sec_d  = adj_r;
          endcase
          zero_set = (hour_d == 5'd0) && (min_d == 6'd0) && (sec_d == 6'd0);
          if (start) begin
            if (zero_set) begin
              mode_d = MODE_IDLE;
            end else begin
              mode_d = MODE_RUN;
              run_d  = 1'b1;
            end
          end
        end
        MODE_RUN: begin
          run_d = run_tog;
          if (!run_tog && cancel) begin
            mode_d = MODE_IDLE;
          end else if (zero_now) begin
            mode_d = MODE_FINISH;
            run_d  = 1'b0;
            left_d = cfg_i.beep_duration;
          end
        end
        default: begin
          armed_d = 1'b1;
          if (cancel || left_q == 8'd0) begin
            mode_d  = MODE_IDLE;
            armed_d = 1'b0;
            level_d = 1'b0;
          end
        end
      endcase
    end
  end

  // State registers, updated once for each word that moves to the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q  <= 5'd0;
      min_q   <= 6'd0;
      sec_q   <= 6'd0;
      mode_q  <= MODE_IDLE;
      field_q <= FIELD_HOURS;
      run_q   <= 1'b0;
      blink_q <= 1'b0;
      armed_q <= 1'b0;
      left_q  <= 8'd0;
      level_q <= 1'b0;
      sdiv_q  <= 6'd0;
      bdiv_q  <= 4'd0;
      pdiv_q  <= 4'd0;
    end else if (step_i) begin
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      mode_q  <= mode_d;
      field_q <= field_d;
      run_q   <= run_d;
      blink_q <= blink_d;
      armed_q <= armed_d;
      left_q  <= left_d;
      level_q <= level_d;
      sdiv_q  <= sdiv_d;
      bdiv_q  <= bdiv_d;
      pdiv_q  <= pdiv_d;
    end
  end

  // Result word built from the state after this step.
  always_comb begin
    res_o.hours          = hour_d;
    res_o.minutes        = min_d;
    res_o.seconds        = sec_d;
    res_o.mode           = mode_d;
    res_o.selected_field = field_d;
    res_o.counting       = run_d;
    res_o.blink          = blink_d;
    res_o.blank_field    = (mode_d == MODE_SET && blink_d) ? field_d + 2'd1 : 2'd0;
    res_o.beeper         = level_d;
  end

`ifndef NO_ASSERTIONS
  // Set and countdown logic keep every time field within its range.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q <= HOUR_TOP) && (min_q <= MS_TOP) && (sec_q <= MS_TOP))
    else $error("time field out of range");

  // The count is never running outside the running mode.
  a_run_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (mode_q == MODE_RUN))
    else $error("run flag set outside running mode");

  // The beeper is only armed in the finished mode.
  a_armed_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (mode_q == MODE_FINISH))
    else $error("beeper armed outside finished mode");
`endif

endmodule

>>> rtl/hms_countdown_timer_top.sv
// Top level of the H:M:S countdown timer: input register, core, result register.
// Depends on hmsct_pkg, hmsct_cfg_regs and hmsct_core.
//
//  Channel   Direction  Handshake             Payload
//  in        in         in_valid_i/in_stall_o command_i, panel_key_i, remote_code_i
//  out       out        out_valid_o/out_stall_i hours_o .. beeper_o
//  cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word is taken every cycle while in_stall_o is low. Each word passes the input
// register and then the result register; the timer state is updated as a word
// moves from the input register into the result register.
// Reset sets the registers to their defaults and the time to 00:00:00 in idle mode.
// A stall on the output holds the result; the input register then fills and
// the input stalls in turn.
module hms_countdown_timer_top
  import hmsct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [1:0] panel_key_i,
  input  logic [2:0] remote_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] hours_o,
  output logic [5:0] minutes_o,
  output logic [5:0] seconds_o,
  output logic [1:0] mode_o,
  output logic [1:0] selected_field_o,
  output logic       counting_o,
  output logic       blink_o,
  output logic [1:0] blank_field_o,
  output logic       beeper_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t       cfg;
  res_t       res_next;
  res_t       res_q;
  logic       in_valid_q;
  logic       cmd_q;
  logic [1:0] panel_q;
  logic [2:0] remote_q;
  logic       out_valid_q;
  logic       accept;
  logic       advance;

  hmsct_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // A word moves on when the result register is empty or being emptied.
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= command_i;
      panel_q  <= panel_key_i;
      remote_q <= remote_code_i;
    end
  end

  hmsct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cmd_i    (cmd_q),
    .panel_i  (panel_q),
    .remote_i (remote_q),
    .cfg_i    (cfg),
    .res_o    (res_next)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hours_o          = res_q.hours;
  assign minutes_o        = res_q.minutes;
  assign seconds_o        = res_q.seconds;
  assign mode_o           = res_q.mode;
  assign selected_field_o = res_q.selected_field;
  assign counting_o       = res_q.counting;
  assign blink_o          = res_q.blink;
  assign blank_field_o    = res_q.blank_field;
  assign beeper_o         = res_q.beeper;

`ifndef NO_ASSERTIONS
  // Every word that leaves the input register shows up as a result.
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("word advanced without a result");

  // A field is blanked only in set mode.
  a_blank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.blank_field != 2'd0) |-> (res_q.mode == MODE_SET))
    else $error("field blanked outside set mode");

  // The finished mode never reports a running count.
  a_finish_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.mode == MODE_FINISH) |-> !res_q.counting)
    else $error("count running in finished mode");
`endif

endmodule
